>>> design/aflm_pkg.sv
package aflm_pkg;

    localparam int HOP_SIZE     = 512;
    localparam int HOP_BITS     = $clog2(HOP_SIZE);
    localparam int MAX_CHANNELS = 64;
    localparam int POS_W        = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = 7;
    localparam int SAMPLE_W     = 16;
    localparam int MIX_W        = 22;
    localparam int MAG_W        = MIX_W;
    localparam int PROD_W       = 2 * MAG_W;
    localparam int SQR_W        = PROD_W + HOP_BITS;
    localparam int RMS_W        = 15;
    localparam int RAD_W        = 2 * RMS_W;
    localparam int REM_W        = RMS_W + 2;
    localparam int COEFF_W      = 17;
    localparam int ACC_W        = RMS_W + 16;
    localparam int SPROD_W      = COEFF_W + ACC_W;
    localparam int PEAK_W       = 16;
    localparam int FRAME_W      = 32;
    localparam int DIV_STEPS    = MAG_W;
    localparam int SQRT_STEPS   = RMS_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam logic [RMS_W-1:0]   POWER_MAX   = '1;
    localparam logic [COEFF_W-1:0] Q16_ONE     = COEFF_W'(65536);
    localparam logic [ACC_W-1:0]   SMOOTH_MAX  = {POWER_MAX, 16'h0000};

    localparam logic [CNT_W-1:0]   RST_CHANNEL_COUNT = CNT_W'(1);
    localparam logic [COEFF_W-1:0] RST_ATTACK        = COEFF_W'(16515);
    localparam logic [COEFF_W-1:0] RST_RELEASE       = COEFF_W'(3697);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = COEFF_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF = 2'd2;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic sq_mul;
        logic hop_acc;
        logic sqrt_load;
        logic sqrt_step;
        logic smooth_mul;
        logic frame_load;
    } t_dp_cmd;

    typedef struct packed {
        logic group_done;
        logic hop_last;
        logic out_free;
    } t_dp_status;

endpackage

>>> design/aflm_ctrl.sv
module aflm_ctrl import aflm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_RAD  = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.group_done) begin
                        o_cmd.div_start = 1'b1;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.sq_mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.hop_acc = 1'b1;
                n_state = i_status.hop_last ? S_RAD : S_IDLE;
            end
            S_RAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_step  = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.smooth_mul = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.frame_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> design/aflm_dp.sv
module aflm_dp import aflm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [RMS_W-1:0]      o_level_power,
    output logic [RMS_W-1:0]      o_raw_rms,
    output logic [PEAK_W-1:0]     o_peak_level,
    output logic                  o_is_silent,
    output logic                  o_power_changed,
    output logic [FRAME_W-1:0]    o_frame_number
);

    // configuration
    logic [CNT_W-1:0]   r_channel_count;
    logic [COEFF_W-1:0] r_attack_coeff;
    logic [COEFF_W-1:0] r_release_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_attack_coeff  <= RST_ATTACK;
            r_release_coeff <= RST_RELEASE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CNT_W-1:0];
                CFG_ATTACK_COEFF:  r_attack_coeff  <= i_cfg_data;
                CFG_RELEASE_COEFF: r_release_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel mix
    logic [CNT_W-1:0]        eff_count;
    logic [POS_W-1:0]        r_chan_pos;
    logic signed [MIX_W-1:0] r_mix_sum;
    logic [CNT_W-1:0]        pos_next;
    logic signed [MIX_W-1:0] mix_next;
    logic [MAG_W-1:0]        mix_mag;

    always_comb begin
        if (r_channel_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_channel_count > CNT_W'(MAX_CHANNELS)) begin
            eff_count = CNT_W'(MAX_CHANNELS);
        end else begin
            eff_count = r_channel_count;
        end
    end

    assign pos_next = CNT_W'(r_chan_pos) + CNT_W'(1);
    assign mix_next = r_mix_sum + MIX_W'(signed'(i_sample));
    assign mix_mag  = mix_next[MIX_W-1] ? MAG_W'(-mix_next) : MAG_W'(mix_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_pos <= '0;
            r_mix_sum  <= '0;
        end else if (i_cmd.accept) begin
            if (o_status.group_done) begin
                r_chan_pos <= '0;
                r_mix_sum  <= '0;
            end else begin
                r_chan_pos <= pos_next[POS_W-1:0];
                r_mix_sum  <= mix_next;
            end
        end
    end

    // serial divide of the group magnitude by the channel count
    logic [MAG_W-1:0] r_div_q;
    logic [CNT_W-1:0] r_div_rem;
    logic [CNT_W-1:0] r_div_d;
    logic [CNT_W-1:0] div_try;
    logic             div_ge;

    assign div_try = {r_div_rem[CNT_W-2:0], r_div_q[MAG_W-1]};
    assign div_ge  = (div_try >= r_div_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_q   <= mix_mag;
            r_div_rem <= '0;
            r_div_d   <= eff_count;
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_ge ? (div_try - r_div_d) : div_try;
            r_div_q   <= {r_div_q[MAG_W-2:0], div_ge};
        end
    end

    // hop accumulation
    logic [PROD_W-1:0]   r_sq_prod;
    logic [SQR_W-1:0]    r_square_sum;
    logic [MAG_W-1:0]    r_peak;
    logic [HOP_BITS-1:0] r_hop_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_mul) begin
            r_sq_prod <= PROD_W'(r_div_q) * PROD_W'(r_div_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_sum <= '0;
            r_peak       <= '0;
            r_hop_pos    <= '0;
        end else if (i_cmd.hop_acc) begin
            r_square_sum <= r_square_sum + SQR_W'(r_sq_prod);
            if (r_div_q > r_peak) begin
                r_peak <= r_div_q;
            end
            r_hop_pos <= r_hop_pos + HOP_BITS'(1);
        end else if (i_cmd.frame_load) begin
            r_square_sum <= '0;
            r_peak       <= '0;
        end
    end

    // square root of the mean square, two radicand bits per step
    logic [RAD_W-1:0]   r_sq_rad;
    logic               r_sq_over;
    logic [REM_W-1:0]   r_sq_rem;
    logic [RMS_W-1:0]   r_sq_root;
    logic [REM_W+1:0]   sq_try;
    logic [REM_W+1:0]   sq_trial;
    logic               sq_ge;
    logic [RMS_W-1:0]   rms;

    assign sq_try   = {r_sq_rem, r_sq_rad[RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_sq_root, 2'b01};
    assign sq_ge    = (sq_try >= sq_trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_sq_rad  <= r_square_sum[HOP_BITS +: RAD_W];
            r_sq_over <= |r_square_sum[SQR_W-1:HOP_BITS+RAD_W];
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_rad  <= {r_sq_rad[RAD_W-3:0], 2'b00};
            r_sq_rem  <= sq_ge ? REM_W'(sq_try - sq_trial) : REM_W'(sq_try);
            r_sq_root <= {r_sq_root[RMS_W-2:0], sq_ge};
        end
    end

    assign rms = r_sq_over ? POWER_MAX : r_sq_root;

    // attack / release smoothing
    logic [ACC_W-1:0]   r_smooth;
    logic [SPROD_W-1:0] r_sm_prod;
    logic               r_rise;
    logic [RMS_W-1:0]   r_rms;
    logic [ACC_W-1:0]   target;
    logic               rise;
    logic [ACC_W-1:0]   delta;
    logic [COEFF_W-1:0] coeff_sel;
    logic [COEFF_W-1:0] coeff;
    logic [31:0]        sm_step;
    logic [ACC_W+1:0]   sm_sum;
    logic [ACC_W-1:0]   smooth_new;
    logic [31:0]        power_sum;
    logic [RMS_W-1:0]   power;

    assign target    = {rms, 16'h0000};
    assign rise      = (target > r_smooth);
    assign delta     = rise ? (target - r_smooth) : (r_smooth - target);
    assign coeff_sel = rise ? r_attack_coeff : r_release_coeff;
    assign coeff     = (coeff_sel > Q16_ONE) ? Q16_ONE : coeff_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.smooth_mul) begin
            r_sm_prod <= SPROD_W'(coeff) * SPROD_W'(delta);
            r_rise    <= rise;
            r_rms     <= rms;
        end
    end

    assign sm_step = r_sm_prod[SPROD_W-1:16];
    assign sm_sum  = (ACC_W+2)'(r_smooth) + (ACC_W+2)'(sm_step);

    always_comb begin
        if (r_rise) begin
            smooth_new = (sm_sum > (ACC_W+2)'(SMOOTH_MAX)) ? SMOOTH_MAX : sm_sum[ACC_W-1:0];
        end else if (sm_step > 32'(r_smooth)) begin
            smooth_new = '0;
        end else begin
            smooth_new = r_smooth - sm_step[ACC_W-1:0];
        end
    end

    assign power_sum = 32'(smooth_new) + 32'd32768;
    assign power     = (power_sum[31:16] > 16'(POWER_MAX)) ? POWER_MAX
                                                           : power_sum[16 +: RMS_W];

    // frame result register
    logic                  r_out_valid;
    logic [RMS_W-1:0]      r_level_power;
    logic [RMS_W-1:0]      r_raw_rms;
    logic [PEAK_W-1:0]     r_peak_level;
    logic                  r_is_silent;
    logic                  r_power_changed;
    logic [FRAME_W-1:0]    r_frame_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_smooth      <= '0;
            r_level_power <= '0;
            r_frame_cnt   <= '0;
        end else if (i_cmd.frame_load) begin
            r_out_valid   <= 1'b1;
            r_smooth      <= smooth_new;
            r_level_power <= power;
            r_frame_cnt   <= r_frame_cnt + FRAME_W'(1);
        end else if (!i_out_stall) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_load) begin
            r_raw_rms       <= r_rms;
            r_peak_level    <= r_peak[PEAK_W-1:0];
            r_is_silent     <= (r_square_sum == '0);
            r_power_changed <= (power != r_level_power);
        end
    end

    assign o_status.group_done = (pos_next >= eff_count);
    assign o_status.hop_last   = (r_hop_pos == HOP_BITS'(HOP_SIZE - 1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_level_power   = r_level_power;
    assign o_raw_rms       = r_raw_rms;
    assign o_peak_level    = r_peak_level;
    assign o_is_silent     = r_is_silent;
    assign o_power_changed = r_power_changed;
    assign o_frame_number  = r_frame_cnt;

endmodule

>>> design/audio_frame_level_meter_top.sv
// channel  direction  handshake                  payload
// in       sink       i_in_valid / o_in_stall    i_sample
// out      source     o_out_valid / i_out_stall  level, rms, peak, flags, frame number
// cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// an item that does not close a channel group is mixed in and leaves the block idle
// closing a group runs a 22-step serial divide by the channel count,
// the squaring multiply and the hop accumulate
// closing a hop adds a 15-step square root, the smoothing multiply and the update
// sync active-low reset clears counters and sums and restores register defaults
// a stalled result holds the block in its final step until the output register frees
module audio_frame_level_meter_top import aflm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [RMS_W-1:0]      o_level_power,
    output logic [RMS_W-1:0]      o_raw_rms,
    output logic [PEAK_W-1:0]     o_peak_level,
    output logic                  o_is_silent,
    output logic                  o_power_changed,
    output logic [FRAME_W-1:0]    o_frame_number,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    aflm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    aflm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_sample        (i_sample),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_level_power   (o_level_power),
        .o_raw_rms       (o_raw_rms),
        .o_peak_level    (o_peak_level),
        .o_is_silent     (o_is_silent),
        .o_power_changed (o_power_changed),
        .o_frame_number  (o_frame_number)
    );

endmodule
